### rtl/mclt_pkg.sv
package mclt_pkg;

	localparam int TIMER_BITS_DEF = 20;
	localparam int DIT_W          = 16;
	localparam int LED_W          = 3;
	localparam int DITS_W         = 4;
	localparam int PROD_W         = DIT_W + DITS_W;
	localparam int CFG_IDX_W      = 2;

	localparam logic [7:0] PAT_START   = 8'h35;
	localparam logic [7:0] PAT_END     = 8'h45;
	localparam logic [7:0] PAT_SPACE   = 8'h01;
	localparam logic [7:0] START_MASK  = 8'h10;
	localparam logic [7:0] LOWER_LIMIT = 8'd96;
	localparam logic [7:0] CODE_CR     = 8'd13;
	localparam logic [7:0] CODE_LF     = 8'd10;

	localparam logic [DITS_W-1:0] GAP_SYMBOL = 4'd1;
	localparam logic [DITS_W-1:0] GAP_DAH    = 4'd3;
	localparam logic [DITS_W-1:0] GAP_LETTER = 4'd3;
	localparam logic [DITS_W-1:0] GAP_WORD   = 4'd7;
	localparam logic [DITS_W-1:0] GAP_POLL   = 4'd15;
	localparam logic [DITS_W-1:0] GAP_SPACE  = 4'd4;

	localparam logic [DIT_W-1:0] DIT_TICKS_RST = 16'd300;
	localparam logic [LED_W-1:0] LED_ON_RST    = 3'd7;
	localparam logic [LED_W-1:0] LED_OFF_RST   = 3'd0;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_DIT_TICKS = 2'd0,
		REG_LED_ON    = 2'd1,
		REG_LED_OFF   = 2'd2
	} cfg_reg_t;

	typedef enum logic [2:0] {
		MODE_IDLE  = 3'd0,
		MODE_START = 3'd1,
		MODE_STOP  = 3'd2,
		MODE_CHAR  = 3'd3,
		MODE_SPACE = 3'd4
	} mode_t;

	typedef struct packed {
		logic             busy_res;
		logic             char_taken;
		logic [LED_W-1:0] led_value;
		logic             led_lit;
	} result_t;

	function automatic logic [7:0] code_lookup(input logic [5:0] idx);
		logic [7:0] r;
		case (idx)
			6'd0:  r = 8'h01; 6'd1:  r = 8'h6b; 6'd2:  r = 8'h52; 6'd3:  r = 8'h3b;
			6'd4:  r = 8'h26; 6'd5:  r = 8'h2c; 6'd6:  r = 8'h28; 6'd7:  r = 8'h5e;
			6'd8:  r = 8'h36; 6'd9:  r = 8'h6d; 6'd10: r = 8'h2d; 6'd11: r = 8'h2a;
			6'd12: r = 8'h73; 6'd13: r = 8'h61; 6'd14: r = 8'h55; 6'd15: r = 8'h32;
			6'd16: r = 8'h3f; 6'd17: r = 8'h2f; 6'd18: r = 8'h27; 6'd19: r = 8'h23;
			6'd20: r = 8'h21; 6'd21: r = 8'h20; 6'd22: r = 8'h30; 6'd23: r = 8'h38;
			6'd24: r = 8'h3c; 6'd25: r = 8'h3e; 6'd26: r = 8'h78; 6'd27: r = 8'h6a;
			6'd28: r = 8'h29; 6'd29: r = 8'h31; 6'd30: r = 8'h3a; 6'd31: r = 8'h4c;
			6'd32: r = 8'h5a; 6'd33: r = 8'h05; 6'd34: r = 8'h18; 6'd35: r = 8'h1a;
			6'd36: r = 8'h0c; 6'd37: r = 8'h02; 6'd38: r = 8'h12; 6'd39: r = 8'h0e;
			6'd40: r = 8'h10; 6'd41: r = 8'h04; 6'd42: r = 8'h17; 6'd43: r = 8'h0d;
			6'd44: r = 8'h14; 6'd45: r = 8'h07; 6'd46: r = 8'h06; 6'd47: r = 8'h0f;
			6'd48: r = 8'h16; 6'd49: r = 8'h1d; 6'd50: r = 8'h0a; 6'd51: r = 8'h08;
			6'd52: r = 8'h03; 6'd53: r = 8'h09; 6'd54: r = 8'h11; 6'd55: r = 8'h0b;
			6'd56: r = 8'h19; 6'd57: r = 8'h1b; 6'd58: r = 8'h1c; 6'd59: r = 8'h1e;
			6'd60: r = 8'h88; 6'd61: r = 8'h34; 6'd62: r = 8'h1f; 6'd63: r = 8'h4d;
			default: r = 8'h00;
		endcase
		return r;
	endfunction

	// highest set bit as a one-hot mask, zero for zero
	function automatic logic [7:0] top_bit(input logic [7:0] p);
		logic [7:0] r;
		r = 8'h00;
		for (int i = 0; i < 8; i++) begin
			if (p[i]) begin
				r = 8'(1 << i);
			end
		end
		return r;
	endfunction

endpackage

### rtl/mclt_seq.sv
module mclt_seq #(
	parameter int TIMER_BITS = mclt_pkg::TIMER_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         step_en,
	input  logic                         char_valid,
	input  logic [7:0]                   char_code,
	input  logic [mclt_pkg::DIT_W-1:0]   dit_ticks,
	input  logic [mclt_pkg::LED_W-1:0]   led_on_value,
	input  logic [mclt_pkg::LED_W-1:0]   led_off_value,
	output mclt_pkg::result_t            res,
	output logic [TIMER_BITS-1:0]        ticks_left
);
	import mclt_pkg::*;

	localparam int CMP_W = (TIMER_BITS > PROD_W) ? TIMER_BITS : PROD_W;

	mode_t               mode_q, mode_d;
	logic [7:0]          pat_q, pat_d;
	logic [7:0]          mask_q, mask_d;
	logic                on_q, on_d;
	logic [LED_W-1:0]    val_q, val_d;
	logic [TIMER_BITS-1:0] ticks_q, ticks_d, ticks_dec;
	logic                took;

	logic [7:0]          code_fold;
	logic [7:0]          fetch_pat;
	logic [7:0]          p;
	logic [7:0]          m;
	logic                timer_en;
	logic [DITS_W-1:0]   dits;
	logic [PROD_W-1:0]   prod;
	logic [CMP_W-1:0]    prod_w;
	logic [CMP_W-1:0]    max_w;

	// character fetch
	always_comb begin
		code_fold = (char_code > LOWER_LIMIT) ? char_code - 8'd32 : char_code;
		if (!char_valid) begin
			fetch_pat = 8'h00;
		end else if (char_code == CODE_CR || char_code == CODE_LF) begin
			fetch_pat = PAT_END;
		end else if (char_code == 8'h00) begin
			fetch_pat = 8'h00;
		end else begin
			fetch_pat = code_lookup(6'(code_fold - 8'd32));
		end
	end

	// next state
	always_comb begin
		mode_d    = mode_q;
		pat_d     = pat_q;
		mask_d    = mask_q;
		on_d      = on_q;
		val_d     = val_q;
		took      = 1'b0;
		timer_en  = 1'b0;
		dits      = GAP_SYMBOL;
		p         = fetch_pat;
		m         = 8'h00;
		ticks_dec = (ticks_q != '0) ? ticks_q - 1'b1 : ticks_q;

		if (ticks_dec == '0) begin
			if (mode_q == MODE_IDLE) begin
				took  = char_valid;
				pat_d = fetch_pat;
				if (fetch_pat != 8'h00) begin
					mode_d   = MODE_CHAR;
					if (fetch_pat == PAT_SPACE) begin
						mode_d = MODE_START;
						pat_d  = PAT_START;
						mask_d = START_MASK - 8'h01;
					end else begin
						mask_d = top_bit(fetch_pat);
					end
					on_d     = 1'b0;
					timer_en = 1'b1;
					dits     = GAP_SYMBOL;
				end
			end else if (on_q) begin
				dits = GAP_SYMBOL;
				if (mask_q == 8'h01) begin
					dits = GAP_LETTER;
					if (mode_q == MODE_START) begin
						dits   = GAP_WORD;
						mode_d = MODE_SPACE;
					end else if (mode_q == MODE_STOP) begin
						dits   = GAP_WORD;
						mode_d = MODE_IDLE;
					end
				end
				on_d     = 1'b0;
				timer_en = 1'b1;
			end else begin
				m      = mask_q >> 1;
				mask_d = m;
				if (m != 8'h00) begin
					on_d     = 1'b1;
					timer_en = 1'b1;
					dits     = ((pat_q & m) != 8'h00) ? GAP_DAH : GAP_SYMBOL;
				end else begin
					took  = char_valid;
					pat_d = fetch_pat;
					if (fetch_pat == 8'h00 && mode_q != MODE_SPACE) begin
						timer_en = 1'b1;
						dits     = GAP_POLL;
					end else begin
						if (fetch_pat == 8'h00) begin
							mode_d = MODE_STOP;
							p      = PAT_END;
						end
						if (p == PAT_SPACE && mode_q != MODE_SPACE) begin
							mode_d   = MODE_SPACE;
							pat_d    = p;
							on_d     = 1'b0;
							timer_en = 1'b1;
							dits     = GAP_SPACE;
						end else begin
							if (p == PAT_SPACE) begin
								mode_d = MODE_START;
								p      = PAT_START;
							end
							pat_d    = p;
							m        = top_bit(p) >> 1;
							mask_d   = m;
							on_d     = 1'b1;
							timer_en = 1'b1;
							dits     = ((p & m) != 8'h00) ? GAP_DAH : GAP_SYMBOL;
						end
					end
				end
			end
		end

		if (timer_en && !(on_d == on_q && mode_q != MODE_IDLE && !on_q && dits == GAP_POLL
			&& mask_d == 8'h00 && fetch_pat == 8'h00)) begin
			val_d = on_d ? led_on_value : led_off_value;
		end
	end

	// duration, saturated to the timer width
	always_comb begin
		prod    = PROD_W'(dits) * PROD_W'(dit_ticks);
		prod_w  = CMP_W'(prod);
		max_w   = CMP_W'({TIMER_BITS{1'b1}});
		ticks_d = ticks_dec;
		if (timer_en) begin
			ticks_d = (prod_w > max_w) ? max_w[TIMER_BITS-1:0] : prod_w[TIMER_BITS-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= MODE_IDLE;
			pat_q   <= 8'h00;
			mask_q  <= 8'h00;
			on_q    <= 1'b0;
			val_q   <= '0;
			ticks_q <= '0;
		end else if (step_en) begin
			mode_q  <= mode_d;
			pat_q   <= pat_d;
			mask_q  <= mask_d;
			on_q    <= on_d;
			val_q   <= val_d;
			ticks_q <= ticks_d;
		end
	end

	always_comb begin
		res.led_lit    = on_d;
		res.led_value  = val_d;
		res.char_taken = took;
		res.busy_res   = (mode_d != MODE_IDLE);
	end

	assign ticks_left = ticks_q;

endmodule

### rtl/morse_code_led_transmitter_core.sv
// Morse code LED transmitter. Every input transfer is one timer tick that may offer an ASCII
// character; every tick yields exactly one result transfer with the LED state after that tick
// and whether the character was consumed. CR and LF send the end prosign, letters are folded
// to upper case. The block takes one tick per clock cycle unless the output stalls. A tick sits in an
// input register, the sequencer step (table lookup, priority encode, one 4x16 multiply for the
// duration) runs from it and lands in the output register when the output can advance. An
// output stall holds the input register and then backpressures the input side.
module morse_code_led_transmitter_core #(
	parameter int TIMER_BITS = mclt_pkg::TIMER_BITS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	input  logic [15:0]                      s_tdata,  // char_valid, char_code, zero fill
	output logic                             m_tvalid,
	input  logic                             m_tready,
	output logic [7:0]                       m_tdata,  // led_lit, led_value, char_taken, busy_res, zero fill
	input  logic                             cfg_we,
	input  logic [mclt_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [mclt_pkg::DIT_W-1:0]       cfg_wdata
);
	import mclt_pkg::*;

	logic                  valid_s1;
	logic                  char_valid_s1;
	logic [7:0]            char_code_s1;
	logic                  adv;
	result_t               res;
	result_t               out_q;
	logic                  out_valid_q;
	logic [DIT_W-1:0]      dit_ticks_q;
	logic [LED_W-1:0]      led_on_q;
	logic [LED_W-1:0]      led_off_q;
	logic [TIMER_BITS-1:0] ticks_left;

	assign adv      = valid_s1 && (!out_valid_q || m_tready);
	assign s_tready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dit_ticks_q <= DIT_TICKS_RST;
			led_on_q    <= LED_ON_RST;
			led_off_q   <= LED_OFF_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_DIT_TICKS: dit_ticks_q <= cfg_wdata;
				REG_LED_ON:    led_on_q    <= cfg_wdata[LED_W-1:0];
				REG_LED_OFF:   led_off_q   <= cfg_wdata[LED_W-1:0];
				default:       ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			char_valid_s1 <= s_tdata[0];
			char_code_s1  <= s_tdata[8:1];
		end
	end

	mclt_seq #(
		.TIMER_BITS(TIMER_BITS)
	) u_seq (
		.clk          (clk),
		.arst_n       (arst_n),
		.step_en      (adv),
		.char_valid   (char_valid_s1),
		.char_code    (char_code_s1),
		.dit_ticks    (dit_ticks_q),
		.led_on_value (led_on_q),
		.led_off_value(led_off_q),
		.res          (res),
		.ticks_left   (ticks_left)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_q <= res;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {2'b00, out_q.busy_res, out_q.char_taken, out_q.led_value, out_q.led_lit};

	a_stall_has_result: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> m_tvalid)
		else $error("input stalled without a pending result");

	a_timer_counts_down: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && ticks_left > TIMER_BITS'(1)) |=> ticks_left == $past(ticks_left) - 1'b1)
		else $error("timer did not count down while running");

	a_taken_only_when_offered: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && res.char_taken) |-> char_valid_s1)
		else $error("character taken that was not offered");

endmodule
